[rtl/lcs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared constants, codes and helper functions for the list colouring search.
// ----------------------------------------------------------------------------
package lcs_pkg;

	localparam int unsigned MAX_VERTICES_DEF = 32;

	// colour code of a vertex with no colour
	localparam logic [1:0] UNCOLOURED = 2'd3;

	// action codes of an input word
	typedef enum logic [1:0] {
		ACT_LOAD_ADJ  = 2'd0,
		ACT_LOAD_LIST = 2'd1,
		ACT_START     = 2'd2,
		ACT_NONE      = 2'd3
	} action_t;

	// population count of a 32 bit word
	function automatic logic [5:0] pop32(input logic [31:0] x);
		logic [5:0] c;
		c = '0;
		for (int i = 0; i < 32; i++) begin
			c = c + 6'(x[i]);
		end
		return c;
	endfunction

	// population count of a 3 bit colour list
	function automatic logic [1:0] pop3(input logic [2:0] x);
		return 2'(x[0]) + 2'(x[1]) + 2'(x[2]);
	endfunction

endpackage
`default_nettype wire

[rtl/lcs_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lcs_ram
// Simple dual port synchronous memory, one write and one registered read.
// ----------------------------------------------------------------------------
module lcs_ram #(
	parameter int unsigned DEPTH = 32,
	parameter int unsigned WIDTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

[rtl/list_colouring_search_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// list_colouring_search_top
// Backtracking list colouring search over a graph of up to MAX_VERTICES
// vertices with three colours per vertex list.
// ----------------------------------------------------------------------------
// Usage:
// - vertex_count is written with vertex_count_we while the block is idle.
// - a word is taken at a clock edge with start high and busy low. Load words
//   (adjacency row, colour list) keep busy low, so one can follow every
//   cycle. Load indexes at or above MAX_VERTICES are dropped.
// - a start word raises busy. The block first scans all vertices to build the
//   ordering keys (one adjacency memory read each), then ranks them into the
//   order memory, then runs the depth first search, each step an order memory
//   read, an adjacency memory read and a colour choice. The search loop sets
//   the total time.
// - the result shows for one cycle with result_valid high; busy falls in the
//   same cycle. found and witness stay valid until the next start word is taken.
// - the receiver cannot stall; nothing waits on it.
// - reset clears all control state and colours; memories stay undefined
//   until loaded.
// ----------------------------------------------------------------------------
module list_colouring_search_top #(
	parameter int unsigned MAX_VERTICES = lcs_pkg::MAX_VERTICES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  action,
	input  wire logic [4:0]  vertex_index,
	input  wire logic [31:0] adjacency_row,
	input  wire logic [2:0]  colour_list,
	input  wire logic [31:0] vertex_mask,
	input  wire logic        vertex_count_we,
	input  wire logic [5:0]  vertex_count,
	output logic             result_valid,
	output logic             found,
	output logic [63:0]      witness
);

	localparam int unsigned IW = $clog2(MAX_VERTICES);
	localparam int unsigned CW = $clog2(MAX_VERTICES + 1);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_KEY  = 5'b00010,
		ST_RANK = 5'b00100,
		ST_ORD  = 5'b01000,
		ST_ADJ  = 5'b10000
	} state_t;

	state_t state_q;
	logic   eval_q;

	logic [5:0]  vcount_q;
	logic [31:0] mask_q;
	logic [CW-1:0] m_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] d_q;
	logic [IW-1:0] v_q;
	logic          vld_s1;
	logic [IW-1:0] idx_s1;

	logic [2:0] list_q   [MAX_VERTICES];
	logic [7:0] key_q    [MAX_VERTICES];
	logic [1:0] colour_q [MAX_VERTICES];
	logic [1:0] nt_q     [MAX_VERTICES];

	logic          result_valid_q;
	logic          found_q;

	// memory ports
	logic          adj_we;
	logic [IW-1:0] adj_raddr;
	logic [31:0]   adj_rdata;
	logic          ord_we;
	logic [IW-1:0] ord_waddr;
	logic [IW-1:0] ord_raddr;
	logic [IW-1:0] ord_rdata;

	logic accept;
	logic load_ok;
	logic [31:0] eff_mask;
	logic [5:0]  n_eff;
	logic [IW-1:0] list_raddr;
	logic [2:0]  list_rd;
	logic [31:0] lt_vec;
	logic [5:0]  rank_full;
	logic [IW-1:0] cnt_idx;
	logic [31:0] nb;
	logic [2:0]  forb;
	logic [2:0]  avail;
	logic        pick_ok;
	logic [1:0]  pick_c;
	logic [IW-1:0] d_idx;
	logic [CW-1:0] d_next;

	assign accept  = start && !busy;
	assign load_ok = (6'(vertex_index) < 6'(MAX_VERTICES));
	assign busy    = (state_q != ST_IDLE) || eval_q;
	assign cnt_idx = cnt_q[IW-1:0];
	assign d_idx   = d_q[IW-1:0];
	assign d_next  = d_q + CW'(1);

	// effective mask from the vertex count
	always_comb begin
		n_eff = (vcount_q > 6'(MAX_VERTICES)) ? 6'(MAX_VERTICES) : vcount_q;
		for (int i = 0; i < 32; i++) begin
			eff_mask[i] = vertex_mask[i] && (6'(i) < n_eff);
		end
	end

	// adjacency memory
	assign adj_we    = accept && (action == lcs_pkg::ACT_LOAD_ADJ) && load_ok;
	assign adj_raddr = (state_q == ST_ADJ) ? ord_rdata : cnt_idx;

	lcs_ram #(.DEPTH(MAX_VERTICES), .WIDTH(32)) u_adj (
		.clk   (clk),
		.we    (adj_we),
		.waddr (vertex_index[IW-1:0]),
		.wdata (adjacency_row),
		.raddr (adj_raddr),
		.rdata (adj_rdata)
	);

	// search order memory
	assign ord_we    = (state_q == ST_RANK) && mask_q[cnt_idx];
	assign ord_waddr = rank_full[IW-1:0];
	assign ord_raddr = d_idx;

	lcs_ram #(.DEPTH(MAX_VERTICES), .WIDTH(IW)) u_ord (
		.clk   (clk),
		.we    (ord_we),
		.waddr (ord_waddr),
		.wdata (cnt_idx),
		.raddr (ord_raddr),
		.rdata (ord_rdata)
	);

	// colour list read
	assign list_raddr = eval_q ? v_q : idx_s1;
	assign list_rd    = list_q[list_raddr];

	// rank of the current vertex among masked vertices
	always_comb begin
		lt_vec = '0;
		for (int u = 0; u < MAX_VERTICES; u++) begin
			lt_vec[u] = mask_q[u] &&
				({key_q[u], 5'(u)} < {key_q[cnt_idx], 5'(cnt_idx)});
		end
		rank_full = lcs_pkg::pop32(lt_vec);
	end

	// colours blocked by coloured neighbours, then the lowest free colour not below the next colour to try
	always_comb begin
		nb   = adj_rdata & mask_q;
		forb = '0;
		for (int j = 0; j < MAX_VERTICES; j++) begin
			if (nb[j] && colour_q[j] != lcs_pkg::UNCOLOURED) begin
				forb = forb | (3'b001 << colour_q[j]);
			end
		end
		avail   = list_rd & ~forb;
		pick_ok = 1'b0;
		pick_c  = lcs_pkg::UNCOLOURED;
		for (int c = 2; c >= 0; c--) begin
			if (2'(c) >= nt_q[d_idx] && avail[c]) begin
				pick_ok = 1'b1;
				pick_c  = 2'(c);
			end
		end
	end

	// list store
	always_ff @(posedge clk) begin
		if (accept && action == lcs_pkg::ACT_LOAD_LIST && load_ok) begin
			list_q[vertex_index[IW-1:0]] <= colour_list;
		end
	end

	// ordering keys: short list first, then high degree
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			key_q[idx_s1] <= {lcs_pkg::pop3(list_rd),
				6'd63 - lcs_pkg::pop32(adj_rdata & mask_q)};
		end
	end

	// vertex count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= 6'd32;
		end else if (vertex_count_we) begin
			vcount_q <= vertex_count;
		end
	end

	// search control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			eval_q         <= 1'b0;
			mask_q         <= '0;
			m_q            <= '0;
			cnt_q          <= '0;
			d_q            <= '0;
			v_q            <= '0;
			vld_s1         <= 1'b0;
			idx_s1         <= '0;
			result_valid_q <= 1'b0;
			found_q        <= 1'b0;
			for (int i = 0; i < MAX_VERTICES; i++) begin
				colour_q[i] <= lcs_pkg::UNCOLOURED;
				nt_q[i]     <= '0;
			end
		end else begin
			result_valid_q <= 1'b0;
			vld_s1         <= 1'b0;
			if (eval_q) begin
				eval_q <= 1'b0;
				state_q <= ST_ORD;
				if (pick_ok) begin
					colour_q[v_q] <= pick_c;
					nt_q[d_idx]   <= pick_c + 2'd1;
					d_q           <= d_next;
					if (d_next < m_q) begin
						nt_q[d_next[IW-1:0]] <= '0;
					end
				end else begin
					nt_q[d_idx] <= '0;
					if (d_q == '0) begin
						state_q        <= ST_IDLE;
						result_valid_q <= 1'b1;
						found_q        <= 1'b0;
						for (int i = 0; i < MAX_VERTICES; i++) begin
							colour_q[i] <= lcs_pkg::UNCOLOURED;
						end
					end else begin
						d_q <= d_q - CW'(1);
					end
				end
			end else begin
				case (state_q)
					ST_IDLE: begin
						if (accept && action == lcs_pkg::ACT_START) begin
							state_q <= ST_KEY;
							mask_q  <= eff_mask;
							m_q     <= CW'(lcs_pkg::pop32(eff_mask));
							cnt_q   <= '0;
							d_q     <= '0;
							for (int i = 0; i < MAX_VERTICES; i++) begin
								colour_q[i] <= lcs_pkg::UNCOLOURED;
								nt_q[i]     <= '0;
							end
						end
					end
					ST_KEY: begin
						if (cnt_q == CW'(MAX_VERTICES)) begin
							state_q <= ST_RANK;
							cnt_q   <= '0;
						end else begin
							vld_s1 <= 1'b1;
							idx_s1 <= cnt_idx;
							cnt_q  <= cnt_q + CW'(1);
						end
					end
					ST_RANK: begin
						if (cnt_q == CW'(MAX_VERTICES - 1)) begin
							state_q <= ST_ORD;
						end
						cnt_q <= cnt_q + CW'(1);
					end
					ST_ORD: begin
						if (d_q >= m_q) begin
							state_q        <= ST_IDLE;
							result_valid_q <= 1'b1;
							found_q        <= 1'b1;
						end else begin
							state_q <= ST_ADJ;
						end
					end
					ST_ADJ: begin
						v_q              <= ord_rdata;
						colour_q[ord_rdata] <= lcs_pkg::UNCOLOURED;
						eval_q           <= 1'b1;
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

	// result ports
	assign result_valid = result_valid_q;
	assign found        = found_q;

	always_comb begin
		witness = '1;
		for (int i = 0; i < MAX_VERTICES; i++) begin
			witness[2*i +: 2] = colour_q[i];
		end
	end

endmodule
`default_nettype wire

[bench/list_colouring_search_top_test.sv]
// ----------------------------------------------------------------------------
// list_colouring_search_top_test
// Self-checking bench for the list colouring search. Loads adjacency rows and
// colour lists, sweeps the vertex count, and starts searches on directed and
// random graphs. A local predictor computes found and witness for each start
// word and the checker compares every result strobe against the oldest one.
// ----------------------------------------------------------------------------
module list_colouring_search_top_test;

	// cap on search steps per start so runs stay short
	localparam int STEP_BUDGET = 600;
	localparam int STALL_LIMIT = 40000;

	typedef struct packed {
		logic        found;
		logic [63:0] witness;
	} colouring_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  action;
	logic [4:0]  vertex_index;
	logic [31:0] adjacency_row;
	logic [2:0]  colour_list;
	logic [31:0] vertex_mask;
	logic        vertex_count_we;
	logic [5:0]  vertex_count;
	logic        result_valid;
	logic        found;
	logic [63:0] witness;

	// predictor copy of the block state
	logic [31:0] adj_model [32];
	logic [2:0]  list_model [32];
	logic [5:0]  count_model;

	colouring_t  expected_colourings [$];
	int          errors;
	int          idle_enable;
	int          n_starts;
	int          n_found;
	int          n_loads;
	int          n_counts;
	int          stall_cycles;

	list_colouring_search_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.action         (action),
		.vertex_index   (vertex_index),
		.adjacency_row  (adjacency_row),
		.colour_list    (colour_list),
		.vertex_mask    (vertex_mask),
		.vertex_count_we(vertex_count_we),
		.vertex_count   (vertex_count),
		.result_valid   (result_valid),
		.found          (found),
		.witness        (witness)
	);

	// clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// effective mask under the current vertex count
	function automatic logic [31:0] clip_mask(input logic [31:0] m);
		int n;
		n = (count_model > 32) ? 32 : int'(count_model);
		return m & 32'((64'd1 << n) - 64'd1);
	endfunction

	// ordered depth first list colouring, also counting search steps
	function automatic void predict_colouring(input logic [31:0] m, output colouring_t res,
			output int steps);
		logic [4:0]  order [32];
		logic [1:0]  col [32];
		logic [1:0]  next_c [32];
		logic [2:0]  avail;
		logic [31:0] nb;
		logic [4:0]  v;
		int          cnt, d, j, c, la, lb, da, db;
		logic        ahead;
		cnt = 0;
		for (int i = 0; i < 32; i++) begin
			col[i] = lcs_pkg::UNCOLOURED;
			next_c[i] = 2'd0;
			order[i] = 5'd0;
		end
		// insertion by list size, then degree in mask, then index
		for (int i = 0; i < 32; i++) begin
			if (m[i]) begin
				j = cnt;
				while (j > 0) begin
					la = $countones(list_model[i]);
					lb = $countones(list_model[order[j-1]]);
					da = $countones(adj_model[i] & m);
					db = $countones(adj_model[order[j-1]] & m);
					if (la != lb) ahead = la < lb;
					else if (da != db) ahead = da > db;
					else ahead = i < order[j-1];
					if (!ahead) break;
					order[j] = order[j-1];
					j--;
				end
				order[j] = 5'(i);
				cnt++;
			end
		end
		steps = 0;
		d = 0;
		res.found = 1'b0;
		forever begin
			steps++;
			if (d >= cnt) begin
				res.found = 1'b1;
				break;
			end
			v = order[d];
			col[v] = lcs_pkg::UNCOLOURED;
			avail = list_model[v];
			nb = adj_model[v] & m;
			for (int k = 0; k < 32; k++) begin
				if (nb[k] && col[k] != lcs_pkg::UNCOLOURED) avail[col[k]] = 1'b0;
			end
			c = next_c[d];
			while (c < 3 && !avail[c]) c++;
			if (c < 3) begin
				col[v] = 2'(c);
				next_c[d] = 2'(c + 1);
				d++;
				if (d < cnt) next_c[d] = 2'd0;
			end else begin
				next_c[d] = 2'd0;
				if (d == 0) break;
				d--;
			end
		end
		res.witness = '1;
		if (res.found) begin
			for (int i = 0; i < 32; i++) res.witness[2*i +: 2] = col[i];
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %h expected %h", what, got, want);
		errors++;
	endtask

	// drive one word and wait until the block takes it
	task automatic send_word(input lcs_pkg::action_t act, input logic [4:0] idx,
			input logic [31:0] row, input logic [2:0] lst, input logic [31:0] m);
		colouring_t res;
		int         steps;
		if (idle_enable && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		action        <= act;
		vertex_index  <= idx;
		adjacency_row <= row;
		colour_list   <= lst;
		vertex_mask   <= m;
		start         <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		// word taken at this edge: update predictor
		case (act)
			lcs_pkg::ACT_LOAD_ADJ: begin
				adj_model[idx] = row;
				n_loads++;
			end
			lcs_pkg::ACT_LOAD_LIST: begin
				list_model[idx] = lst;
				n_loads++;
			end
			lcs_pkg::ACT_START: begin
				predict_colouring(clip_mask(m), res, steps);
				expected_colourings = {expected_colourings, res};
				n_starts++;
				if (res.found) n_found++;
			end
			default: ;
		endcase
	endtask

	// start with a mask trimmed until the search stays within budget
	task automatic start_search(input logic [31:0] m);
		colouring_t res;
		int         steps;
		logic [31:0] em;
		em = clip_mask(m);
		predict_colouring(em, res, steps);
		while (steps > STEP_BUDGET && em != 0) begin
			for (int i = 31; i >= 0; i--) begin
				if (em[i]) begin
					em[i] = 1'b0;
					m[i] = 1'b0;
					break;
				end
			end
			predict_colouring(em, res, steps);
		end
		send_word(lcs_pkg::ACT_START, 5'($urandom), $urandom, 3'($urandom), m);
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (expected_colourings.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_vertex_count(input logic [5:0] value);
		wait_idle();
		vertex_count_we <= 1'b1;
		vertex_count    <= value;
		@(posedge clk);
		vertex_count_we <= 1'b0;
		count_model = value;
		n_counts++;
	endtask

	// load a random, mostly symmetric graph with the given edge density in percent, and colour lists
	task automatic load_random_graph(input int density, input int tight_lists);
		logic [31:0] rows [32];
		logic [2:0]  lst;
		for (int i = 0; i < 32; i++) rows[i] = '0;
		for (int i = 0; i < 32; i++) begin
			for (int j = i + 1; j < 32; j++) begin
				if ($urandom_range(0, 99) < density) begin
					rows[i][j] = 1'b1;
					rows[j][i] = 1'b1;
				end
			end
		end
		for (int i = 0; i < 32; i++) begin
			// occasional self loop or one-sided edge
			if ($urandom_range(0, 19) == 0) rows[i][$urandom_range(0, 31)] ^= 1'b1;
			send_word(lcs_pkg::ACT_LOAD_ADJ, 5'(i), rows[i], 3'($urandom), $urandom);
			if (tight_lists) lst = 3'($urandom_range(0, 7));
			else lst = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'b111;
			send_word(lcs_pkg::ACT_LOAD_LIST, 5'(i), $urandom, lst, $urandom);
		end
	endtask

	task automatic test_directed();
		// every entry written once: empty graph, full lists
		for (int i = 0; i < 32; i++) begin
			send_word(lcs_pkg::ACT_LOAD_ADJ, 5'(i), 32'h0, 3'($urandom), $urandom);
			send_word(lcs_pkg::ACT_LOAD_LIST, 5'(i), $urandom, 3'b111, $urandom);
		end
		start_search(32'hFFFF_FFFF);
		start_search(32'h0);
		// triangle 0-1-2 with full lists, then a clash
		send_word(lcs_pkg::ACT_LOAD_ADJ, 5'd0, 32'h6, 3'b000, 32'h0);
		send_word(lcs_pkg::ACT_LOAD_ADJ, 5'd1, 32'h5, 3'b000, 32'h0);
		send_word(lcs_pkg::ACT_LOAD_ADJ, 5'd2, 32'h3, 3'b000, 32'h0);
		start_search(32'h7);
		send_word(lcs_pkg::ACT_LOAD_LIST, 5'd0, 32'h0, 3'b001, 32'h0);
		send_word(lcs_pkg::ACT_LOAD_LIST, 5'd1, 32'h0, 3'b001, 32'h0);
		start_search(32'h7);
		// empty colour list
		send_word(lcs_pkg::ACT_LOAD_LIST, 5'd31, 32'h0, 3'b000, 32'h0);
		start_search(32'h8000_0000);
		// self loop and a one-sided row
		send_word(lcs_pkg::ACT_LOAD_ADJ, 5'd5, 32'h0000_0020, 3'b000, 32'h0);
		send_word(lcs_pkg::ACT_LOAD_ADJ, 5'd6, 32'h0000_0080, 3'b000, 32'h0);
		send_word(lcs_pkg::ACT_LOAD_LIST, 5'd7, 32'h0, 3'b010, 32'h0);
		send_word(lcs_pkg::ACT_LOAD_LIST, 5'd6, 32'h0, 3'b110, 32'h0);
		start_search(32'h0000_00E0);
		// ignored action, then a mask of every vertex but 31
		send_word(lcs_pkg::ACT_NONE, 5'd31, 32'hFFFF_FFFF, 3'b111, 32'hFFFF_FFFF);
		start_search(32'h7FFF_FFFF);
	endtask

	task automatic test_vertex_count();
		logic [5:0] counts [5] = '{6'd0, 6'd1, 6'd63, 6'd2, 6'd32};
		foreach (counts[k]) begin
			write_vertex_count(counts[k]);
			start_search(32'hFFFF_FFFF);
			start_search($urandom);
		end
	endtask

	task automatic test_random_graphs(input int rounds);
		int r;
		for (int g = 0; g < rounds; g++) begin
			write_vertex_count(($urandom_range(0, 3) == 0) ? 6'd32 : 6'($urandom_range(1, 40)));
			load_random_graph($urandom_range(0, 3) == 0 ? 40 : $urandom_range(2, 20),
				$urandom_range(0, 1));
			for (int k = 0; k < 40; k++) begin
				r = $urandom_range(0, 19);
				if (r < 12) start_search($urandom);
				else if (r < 14) start_search($urandom & $urandom);
				else if (r < 16) send_word(lcs_pkg::ACT_LOAD_LIST, 5'($urandom), $urandom,
					3'($urandom), $urandom);
				else if (r < 18) send_word(lcs_pkg::ACT_LOAD_ADJ, 5'($urandom),
					$urandom & $urandom, 3'($urandom), $urandom);
				else send_word(lcs_pkg::ACT_NONE, 5'($urandom), $urandom, 3'($urandom),
					$urandom);
			end
		end
	endtask

	task automatic test_drain_pause();
		start_search($urandom);
		start <= 1'b0;
		@(posedge clk);
		while (expected_colourings.size() != 0) @(posedge clk);
		start_search($urandom);
	endtask

	task automatic test_back_to_back();
		idle_enable = 0;
		for (int k = 0; k < 40; k++) begin
			if (k % 3 == 0) start_search($urandom);
			else send_word(lcs_pkg::ACT_LOAD_LIST, 5'($urandom), $urandom, 3'b111, $urandom);
		end
	endtask

	// result checker
	always @(posedge clk) begin
		colouring_t want;
		if (arst_n && result_valid) begin
			if (expected_colourings.size() == 0) begin
				report_mismatch("unexpected result", {63'd0, found}, 64'd0);
			end else begin
				want = expected_colourings.pop_front();
				if (found !== want.found) report_mismatch("found", {63'd0, found},
					{63'd0, want.found});
				if (witness !== want.witness) report_mismatch("witness", witness, want.witness);
			end
		end
	end

	// watchdog on cycles with no word moving
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid || vertex_count_we)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("timeout with %0d results pending", expected_colourings.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		errors = 0;
		n_starts = 0;
		n_found = 0;
		n_loads = 0;
		n_counts = 0;
		idle_enable = 1;
		stall_cycles = 0;
		count_model = 6'd32;
		arst_n = 1'b0;
		start = 1'b0;
		action = lcs_pkg::ACT_NONE;
		vertex_index = '0;
		adjacency_row = '0;
		colour_list = '0;
		vertex_mask = '0;
		vertex_count_we = 1'b0;
		vertex_count = 6'd32;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_vertex_count();
		test_random_graphs(8);
		test_drain_pause();
		test_back_to_back();

		wait_idle();
		repeat (20) @(posedge clk);
		$display("covered %0d searches (%0d colourable), %0d loads, %0d vertex count writes",
			n_starts, n_found, n_loads, n_counts);
		$display("mismatches: %0d", errors);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
